// ===== hw/rtl/indexed_max_priority_table_unit_defines.svh =====
// Assertion macros shared by the indexed max-priority table RTL.
`ifndef INDEXED_MAX_PRIORITY_TABLE_UNIT_DEFINES_SVH
`define INDEXED_MAX_PRIORITY_TABLE_UNIT_DEFINES_SVH

// Check a property on clk_i, masked while rst_ni is low.
`define IMPTAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on clk_i at every edge, reset included.
`define IMPTAB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/imptab_pkg.sv =====
// Package for the indexed max-priority table: field widths, defaults, opcodes, control struct.
`timescale 1ns / 1ps

package imptab_pkg;

  localparam int unsigned ENTRIES_DEF   = 256;
  localparam int unsigned PRIO_BITS_DEF = 10;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned AMOUNT_W      = 10;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_INCREASE = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_QUERY    = 2'd3
  } op_e;

  // Control from the sequencer to the best-entry tracker.
  typedef struct packed {
    logic start;   // forget the current best, a new scan begins
    logic sample;  // read data of the delayed scan address is valid
  } best_ctl_t;

endpackage

// ===== hw/rtl/imptab_if.sv =====
// Valid/ready channel interfaces for the table's command and result items.
`timescale 1ns / 1ps

interface imptab_in_if;
  logic                                valid;
  logic                                ready;
  logic [imptab_pkg::OP_W-1:0]         operation;
  logic [imptab_pkg::INDEX_W-1:0]      entry_index;
  logic [imptab_pkg::AMOUNT_W-1:0]     amount;

  modport source (output valid, operation, entry_index, amount, input ready);
  modport sink (input valid, operation, entry_index, amount, output ready);
endinterface

interface imptab_out_if;
  logic                                valid;
  logic                                ready;
  logic                                table_nonempty;
  logic [imptab_pkg::INDEX_W-1:0]      best_entry;

  modport source (output valid, table_nonempty, best_entry, input ready);
  modport sink (input valid, table_nonempty, best_entry, output ready);
endinterface

// ===== hw/rtl/imptab_ram.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module imptab_ram #(
  parameter int unsigned DEPTH = imptab_pkg::ENTRIES_DEF,
  parameter int unsigned WIDTH = 1 + imptab_pkg::PRIO_BITS_DEF + imptab_pkg::STAMP_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/imptab_best.sv =====
// Running best-entry tracker fed by the scan: highest priority, then oldest stamp.
`timescale 1ns / 1ps

module imptab_best #(
  parameter int unsigned ENTRIES       = imptab_pkg::ENTRIES_DEF,
  parameter int unsigned PRIORITY_BITS = imptab_pkg::PRIO_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  imptab_pkg::best_ctl_t             ctl_i,
  input  logic [$clog2(ENTRIES)-1:0]        idx_i,
  input  logic                              active_i,
  input  logic [PRIORITY_BITS-1:0]          prio_i,
  input  logic [imptab_pkg::STAMP_W-1:0]    stamp_i,
  output logic                              found_o,
  output logic [$clog2(ENTRIES)-1:0]        idx_o
);

  localparam int unsigned ADDR_W = $clog2(ENTRIES);

  logic                           found_q, found_d;
  logic [ADDR_W-1:0]              idx_q, idx_d;
  logic [PRIORITY_BITS-1:0]       prio_q, prio_d;
  logic [imptab_pkg::STAMP_W-1:0] stamp_q, stamp_d;
  logic                           better;

  // Strict compares in rising index order leave full ties to the lowest index.
  assign better = active_i &&
                  (!found_q || (prio_i > prio_q) ||
                   ((prio_i == prio_q) && (stamp_i < stamp_q)));

  always_comb begin
    found_d = found_q;
    idx_d   = idx_q;
    prio_d  = prio_q;
    stamp_d = stamp_q;
    if (ctl_i.start) begin
      found_d = 1'b0;
      idx_d   = '0;
    end else if (ctl_i.sample && better) begin
      found_d = 1'b1;
      idx_d   = idx_i;
      prio_d  = prio_i;
      stamp_d = stamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    prio_q  <= prio_d;
    stamp_q <= stamp_d;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;

endmodule

// ===== hw/rtl/indexed_max_priority_table_unit.sv =====
// Top level of the indexed max-priority table: sequencer, entry store and best-entry scan.
//
// Indexed max-priority table. Each entry holds an active mark, a priority and an arrival
// stamp in one word of a single-port-read, single-port-write memory. Insert, increase and
// remove each read their entry as the item is accepted and write the modified word back
// in the next cycle. Query walks the memory one entry per cycle through the read port,
// compares the last entry, and then returns its result once the output register is free;
// the next item is taken only after that. Only one item is in flight at a time. After
// reset the block clears the active marks with a pass over every entry, during which no
// item is taken. Priorities saturate at 2^PRIORITY_BITS - 1; increase and remove on an
// inactive entry change nothing; indexes at or beyond ENTRIES are dropped. On equal
// priority the earlier arrival wins; best_entry carries the low 8 bits of the winning
// index, and 0 when empty.
`timescale 1ns / 1ps
`include "indexed_max_priority_table_unit_defines.svh"

module indexed_max_priority_table_unit #(
  parameter int unsigned ENTRIES       = imptab_pkg::ENTRIES_DEF,
  parameter int unsigned PRIORITY_BITS = imptab_pkg::PRIO_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  imptab_in_if.sink  in_i,
  imptab_out_if.source out_o
);

  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned STAMP_W = imptab_pkg::STAMP_W;
  localparam int unsigned WORD_W  = 1 + PRIORITY_BITS + STAMP_W;
  // Wide enough to hold the index field and ENTRIES itself for the range check.
  localparam int unsigned EXT_W   = (ADDR_W >= imptab_pkg::INDEX_W) ? ADDR_W + 1
                                                                    : imptab_pkg::INDEX_W + 1;
  localparam int unsigned SUM_W   = (PRIORITY_BITS >= imptab_pkg::AMOUNT_W) ? PRIORITY_BITS + 1
                                                                            : imptab_pkg::AMOUNT_W + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Command latched at acceptance.
  imptab_pkg::op_e                  op_q, op_d;
  logic [ADDR_W-1:0]                addr_q, addr_d;
  logic                             in_range_q, in_range_d;
  logic [imptab_pkg::AMOUNT_W-1:0]  amt_q, amt_d;

  logic [ADDR_W-1:0]  clr_q, clr_d;       // clearing pass address
  logic [ADDR_W-1:0]  scan_q, scan_d;     // scan read address
  logic               sample_q, sample_d; // read data of the previous scan address is due
  logic [ADDR_W-1:0]  sidx_q, sidx_d;     // index that the read data belongs to
  logic [STAMP_W-1:0] arr_cnt_q, arr_cnt_d;

  logic                             out_valid_q, out_valid_d;
  logic                             out_nonempty_q, out_nonempty_d;
  logic [imptab_pkg::INDEX_W-1:0]   out_best_q, out_best_d;

  logic                   in_accept;
  logic [EXT_W-1:0]       in_idx_ext;
  logic                   in_in_range;
  logic [ADDR_W-1:0]      in_addr;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [WORD_W-1:0]      mem_rdata;

  logic                     rd_active;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [STAMP_W-1:0]       rd_stamp;

  logic [SUM_W-1:0]         prio_raw;
  logic [SUM_W-1:0]         prio_max_ext;
  logic [PRIORITY_BITS-1:0] prio_sat;

  imptab_pkg::best_ctl_t best_ctl;
  logic                  best_found;
  logic [ADDR_W-1:0]     best_idx;

  // Decode the incoming index: drop anything at or beyond the table depth.
  assign in_idx_ext  = EXT_W'(in_i.entry_index);
  assign in_in_range = in_idx_ext < EXT_W'(ENTRIES);
  assign in_addr     = in_idx_ext[ADDR_W-1:0];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  // Memory word layout: {active, priority, stamp}.
  assign rd_active = mem_rdata[WORD_W-1];
  assign rd_prio   = mem_rdata[STAMP_W +: PRIORITY_BITS];
  assign rd_stamp  = mem_rdata[STAMP_W-1:0];

  // Saturating priority: insert clamps the amount, increase clamps the sum.
  assign prio_max_ext = SUM_W'({PRIORITY_BITS{1'b1}});
  assign prio_raw     = (op_q == imptab_pkg::OP_INSERT) ? SUM_W'(amt_q)
                                                        : SUM_W'(rd_prio) + SUM_W'(amt_q);
  assign prio_sat     = (prio_raw > prio_max_ext) ? {PRIORITY_BITS{1'b1}}
                                                  : prio_raw[PRIORITY_BITS-1:0];

  // Read the scan address while scanning, otherwise the entry of the incoming item.
  assign mem_raddr = (state_q == ST_SCAN) ? scan_q : in_addr;

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    addr_d         = addr_q;
    in_range_d     = in_range_q;
    amt_d          = amt_q;
    clr_d          = clr_q;
    scan_d         = scan_q;
    sample_d       = 1'b0;
    sidx_d         = scan_q;
    arr_cnt_d      = arr_cnt_q;
    out_valid_d    = out_valid_q;
    out_nonempty_d = out_nonempty_q;
    out_best_d     = out_best_q;
    mem_we         = 1'b0;
    mem_waddr      = addr_q;
    mem_wdata      = {1'b0, rd_prio, rd_stamp};
    best_ctl.start  = 1'b0;
    best_ctl.sample = sample_q;

    // Hand off the result item.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // Clear one active mark per cycle.
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LAST_ADDR) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          op_d       = imptab_pkg::op_e'(in_i.operation);
          addr_d     = in_addr;
          in_range_d = in_in_range;
          amt_d      = in_i.amount;
          if (imptab_pkg::op_e'(in_i.operation) == imptab_pkg::OP_QUERY) begin
            best_ctl.start = 1'b1;
            scan_d         = '0;
            state_d        = ST_SCAN;
          end else begin
            state_d = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        // Read data of addr_q is here: modify and write back.
        state_d = ST_IDLE;
        if (in_range_q) begin
          case (op_q)
            imptab_pkg::OP_INSERT: begin
              mem_we    = 1'b1;
              mem_wdata = {1'b1, prio_sat, arr_cnt_q};
              arr_cnt_d = arr_cnt_q + 1'b1;
            end
            imptab_pkg::OP_INCREASE: begin
              mem_we    = rd_active;
              mem_wdata = {1'b1, prio_sat, rd_stamp};
            end
            imptab_pkg::OP_REMOVE: begin
              mem_we    = 1'b1;
              mem_wdata = {1'b0, rd_prio, rd_stamp};
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle; each entry is compared in the cycle after its read.
        sample_d = 1'b1;
        sidx_d   = scan_q;
        if (scan_q == LAST_ADDR) begin
          scan_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // Last entry is compared this cycle.
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d    = 1'b1;
          out_nonempty_d = best_found;
          out_best_d     = imptab_pkg::INDEX_W'(best_idx);
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      scan_q      <= '0;
      sample_q    <= 1'b0;
      arr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      scan_q      <= scan_d;
      sample_q    <= sample_d;
      arr_cnt_q   <= arr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q           <= op_d;
    addr_q         <= addr_d;
    in_range_q     <= in_range_d;
    amt_q          <= amt_d;
    sidx_q         <= sidx_d;
    out_nonempty_q <= out_nonempty_d;
    out_best_q     <= out_best_d;
  end

  imptab_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  imptab_best #(
    .ENTRIES       (ENTRIES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_best (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (best_ctl),
    .idx_i    (sidx_q),
    .active_i (rd_active),
    .prio_i   (rd_prio),
    .stamp_i  (rd_stamp),
    .found_o  (best_found),
    .idx_o    (best_idx)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.table_nonempty = out_nonempty_q;
  assign out_o.best_entry     = out_best_q;

  `IMPTAB_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result item appeared outside the end of a query")
  `IMPTAB_ASSERT(a_stamp_only_on_insert, (arr_cnt_q != $past(arr_cnt_q)) |-> $past((state_q == ST_UPDATE) && (op_q == imptab_pkg::OP_INSERT)), "arrival counter moved without an insert")
  `IMPTAB_ASSERT(a_accept_leaves_idle, in_accept |=> (state_q != ST_IDLE), "sequencer stayed idle after taking an item")
  `IMPTAB_ASSERT(a_scan_then_drain, ((state_q == ST_SCAN) && (scan_q == LAST_ADDR)) |=> ((state_q == ST_DRAIN) && sample_q), "scan end did not drain the last entry")
  `IMPTAB_ASSERT_ALWAYS(a_no_write_in_scan, ((state_q == ST_SCAN) || (state_q == ST_DONE)) |-> !mem_we, "entry store written during a query")

endmodule

// ===== sim/indexed_max_priority_table_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the indexed max-priority table: directed rows, then random traffic.
module indexed_max_priority_table_unit_test;
  import imptab_pkg::*;

  localparam int unsigned ENTRIES      = ENTRIES_DEF;
  localparam int unsigned PRIO_BITS    = PRIO_BITS_DEF;
  localparam int unsigned PRIO_TOP     = (1 << PRIO_BITS) - 1;
  // Random items beside the directed rows; the table-emptying removes come on top.
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          IDLE_PCT     = 23;
  localparam int          EPISODE_LEN  = 40;
  // Long receiver hold-off: several query scans long, so the input side backs up.
  localparam int          HOLD_CYCLES  = 700;
  localparam int          HOLD_AT      = 25;
  // At the end, wait somewhat longer than a full query scan.
  localparam int          DRAIN_CYCLES = ENTRIES + 16;

  typedef struct packed {
    logic               nonempty;
    logic [INDEX_W-1:0] best;
  } best_t;

  // One directed row. Where typed is set, the query result below is the expectation;
  // otherwise the table tracker decides it.
  typedef struct packed {
    op_e                 op;
    logic [INDEX_W-1:0]  idx;
    logic [AMOUNT_W-1:0] amt;
    logic                typed;
    logic                nonempty;
    logic [INDEX_W-1:0]  best;
  } cmd_row_t;

  localparam int DIRECTED_ROWS = 26;
  localparam cmd_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Empty table after reset, then removal and increase of inactive slots.
    '{OP_QUERY,    8'd0,   10'd0,    1'b1, 1'b0, 8'd0},
    '{OP_REMOVE,   8'd5,   10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_INCREASE, 8'd7,   10'd1023, 1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b1, 1'b0, 8'd0},
    // Lowest slot with lowest priority, then highest slot with top priority.
    '{OP_INSERT,   8'd0,   10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b1, 1'b1, 8'd0},
    '{OP_INSERT,   8'd255, 10'd1023, 1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b1, 1'b1, 8'd255},
    // Equal priority: the earlier arrival keeps the lead.
    '{OP_INSERT,   8'd128, 10'd1023, 1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b1, 1'b1, 8'd255},
    // Raise slot 0 to the top, then push it past the top so it saturates.
    '{OP_INCREASE, 8'd0,   10'd1023, 1'b0, 1'b0, 8'd0},
    '{OP_INCREASE, 8'd0,   10'd1,    1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_REMOVE,   8'd0,   10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b0, 1'b0, 8'd0},
    // Insert on an active slot: new priority and a fresh arrival.
    '{OP_INSERT,   8'd255, 10'd5,    1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_REMOVE,   8'd128, 10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b0, 1'b0, 8'd0},
    // Alternating bit patterns on index and amount.
    '{OP_INSERT,   8'd170, 10'd682,  1'b0, 1'b0, 8'd0},
    '{OP_INSERT,   8'd85,  10'd341,  1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b0, 1'b0, 8'd0},
    // Drain the table back to empty.
    '{OP_REMOVE,   8'd255, 10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_REMOVE,   8'd170, 10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_REMOVE,   8'd85,  10'd0,    1'b0, 1'b0, 8'd0},
    '{OP_QUERY,    8'd0,   10'd0,    1'b1, 1'b0, 8'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  imptab_in_if  in_ch ();
  imptab_out_if out_ch ();

  indexed_max_priority_table_unit #(
    .ENTRIES      (ENTRIES),
    .PRIORITY_BITS(PRIO_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the table, updated at each accepted item.
  logic                 slot_active [ENTRIES];
  logic [PRIO_BITS-1:0] slot_prio   [ENTRIES];
  logic [STAMP_W-1:0]   slot_stamp  [ENTRIES];
  logic [STAMP_W-1:0]   arrival_count;

  best_t best_due_q [$];   // query results still owed by the block, oldest first
  int    errors;
  int    results_seen;
  logic  steady;           // set during the stretch where neither side idles

  // Find the active slot with the highest priority; earliest stamp breaks ties,
  // and the scan order makes the lowest index win if stamps ever match.
  function automatic best_t scan_best();
    best_t                r;
    logic [PRIO_BITS-1:0] top_prio;
    logic [STAMP_W-1:0]   top_stamp;
    r         = '0;
    top_prio  = '0;
    top_stamp = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_active[i] && (!r.nonempty || slot_prio[i] > top_prio ||
          (slot_prio[i] == top_prio && slot_stamp[i] < top_stamp))) begin
        r.nonempty = 1'b1;
        r.best     = i[INDEX_W-1:0];
        top_prio   = slot_prio[i];
        top_stamp  = slot_stamp[i];
      end
    end
    return r;
  endfunction

  function automatic logic [PRIO_BITS-1:0] clamp_prio(input int unsigned v);
    return (v > PRIO_TOP) ? PRIO_TOP[PRIO_BITS-1:0] : v[PRIO_BITS-1:0];
  endfunction

  // Advance the shadow table by one accepted item; queue the result a query owes.
  task automatic track_cmd(input op_e op, input logic [INDEX_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt, input logic typed,
                           input best_t typed_result);
    if (op == OP_QUERY) begin
      best_due_q.push_back(typed ? typed_result : scan_best());
    end else if (int'(idx) < ENTRIES) begin
      case (op)
        OP_INSERT: begin
          slot_active[idx] = 1'b1;
          slot_prio[idx]   = clamp_prio(amt);
          slot_stamp[idx]  = arrival_count;
          arrival_count    = arrival_count + 1'b1;
        end
        OP_INCREASE: begin
          if (slot_active[idx]) slot_prio[idx] = clamp_prio(slot_prio[idx] + amt);
        end
        default: begin
          slot_active[idx] = 1'b0;
        end
      endcase
    end
  endtask

  // Offer one item at the falling edge, after a random gap, and hold it until taken.
  // Each step sees one assignment to valid, so back-to-back items keep it high.
  task automatic send_cmd(input op_e op, input logic [INDEX_W-1:0] idx,
                          input logic [AMOUNT_W-1:0] amt, input logic typed,
                          input best_t typed_result);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx;
    in_ch.amount      <= amt;
    do @(posedge clk_i); while (!in_ch.ready);
    track_cmd(op, idx, amt, typed, typed_result);
  endtask

  // Amounts lean on the extremes and on a few small values, so ties and
  // saturation come up often.
  function automatic logic [AMOUNT_W-1:0] pick_amount();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return AMOUNT_W'($urandom_range(3));
      3:       return AMOUNT_W'(1000 + $urandom_range(23));
      default: return AMOUNT_W'($urandom);
    endcase
  endfunction

  function automatic op_e pick_op();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return OP_INSERT;
    if (roll < 60) return OP_INCREASE;
    if (roll < 78) return OP_REMOVE;
    return OP_QUERY;
  endfunction

  // Stimulus: reset, directed rows, then random episodes over a sliding window of slots.
  initial begin
    cmd_row_t           row;
    best_t              row_result;
    int                 n_random;
    int unsigned        win_base;
    int unsigned        win_span;
    logic [INDEX_W-1:0] idx;
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_INSERT;
    in_ch.entry_index = '0;
    in_ch.amount      = '0;
    steady            = 1'b0;
    errors            = 0;
    arrival_count     = '0;
    win_base          = 0;
    win_span          = 1;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_active[i] = 1'b0;
      slot_prio[i]   = '0;
      slot_stamp[i]  = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The block clears its marks after reset; the first item simply waits for ready.
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      row        = DIRECTED[k];
      row_result = '{nonempty: row.nonempty, best: row.best};
      send_cmd(row.op, row.idx, row.amt, row.typed, row_result);
    end

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      // Start a new episode: move the window, and now and then empty the table.
      if (n_random % EPISODE_LEN == 0) begin
        win_base = $urandom_range(ENTRIES - 1);
        win_span = $urandom_range(24, 1);
        if ($urandom_range(2) == 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_active[i])
              send_cmd(OP_REMOVE, i[INDEX_W-1:0], AMOUNT_W'($urandom), 1'b0, '0);
          end
        end
      end
      steady = (n_random >= 500 && n_random < 700);
      if ($urandom_range(99) < 85)
        idx = INDEX_W'(win_base + $urandom_range(win_span - 1));
      else
        idx = INDEX_W'($urandom);
      send_cmd(pick_op(), idx, pick_amount(), 1'b0, '0);
      n_random++;
    end
    steady = 1'b0;

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (best_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("indexed_max_priority_table_unit_test: clean");
    end else begin
      $display("indexed_max_priority_table_unit_test: errors");
    end
    $finish;
  end

  // Result side: random ready at the falling edge, plus one long hold-off that
  // stalls a finished query while the sender keeps offering items.
  initial begin
    int hold_left;
    bit hold_done;
    out_ch.ready = 1'b0;
    hold_left    = 0;
    hold_done    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Check each accepted result against the oldest query still owed.
  initial results_seen = 0;
  always @(posedge clk_i) begin
    best_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (best_due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual nonempty=%0b best=%0d",
                 $realtime, out_ch.table_nonempty, out_ch.best_entry);
      end else begin
        want = best_due_q.pop_front();
        if (out_ch.table_nonempty !== want.nonempty) begin
          errors++;
          $display("%0t: table_nonempty mismatch: expected %0b, actual %0b",
                   $realtime, want.nonempty, out_ch.table_nonempty);
        end
        if (out_ch.best_entry !== want.best) begin
          errors++;
          $display("%0t: best_entry mismatch: expected %0d, actual %0d",
                   $realtime, want.best, out_ch.best_entry);
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("indexed_max_priority_table_unit_test: errors");
    $finish;
  end

endmodule
